FILE: src/sbl_pkg.sv
// ----------------------------------------------------------------------------
// sbl_pkg: shared types and codes of the sorted byte list
// Beat structs for both channels, command and status codes, and the
// command token that walks the row of list cells.
// ----------------------------------------------------------------------------
package sbl_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int VALUE_W      = 8;
  localparam int COUNT_W      = 5;
  localparam int STATUS_W     = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic               command;
    logic [VALUE_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic [VALUE_W-1:0]  smallest;
  } out_beat_t;

  // act: token present; data: value carried (insert) or searched (delete);
  // carry_vld: insert value still looking for a slot; hit: shift under way
  // (insert) or match found (delete); full: insert refused at launch.
  typedef struct packed {
    logic               act;
    logic               cmd;
    logic [VALUE_W-1:0] data;
    logic               carry_vld;
    logic               hit;
    logic               full;
  } sbl_tok_t;

endpackage

FILE: src/sbl_cell.sv
// ----------------------------------------------------------------------------
// sbl_cell: one slot of the sorted byte list
// Holds one value and its valid bit, applies the passing command token and
// hands the updated token to the next cell through its token register.
// ----------------------------------------------------------------------------
module sbl_cell
  import sbl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               hold,
  input  sbl_tok_t           tok_i,
  input  logic [VALUE_W-1:0] nb_val_i,
  input  logic               nb_vld_i,
  output sbl_tok_t           tok_o,
  output logic [VALUE_W-1:0] val_o,
  output logic               vld_o
);

  logic [VALUE_W-1:0] val_r, val_nxt;
  logic               vld_r, vld_nxt;
  sbl_tok_t           tok_r, tok_nxt;

  always_comb begin
    val_nxt = val_r;
    vld_nxt = vld_r;
    tok_nxt = tok_i;
    if (tok_i.act) begin
      if (tok_i.cmd == CMD_INSERT) begin
        if (tok_i.carry_vld) begin
          if (!vld_r) begin
            // drop the carried value into the first free slot
            val_nxt           = tok_i.data;
            vld_nxt           = 1'b1;
            tok_nxt.carry_vld = 1'b0;
          end else if (tok_i.hit || (val_r > tok_i.data)) begin
            // swap: keep the carried value, carry the old one onward
            val_nxt      = tok_i.data;
            tok_nxt.data = val_r;
            tok_nxt.hit  = 1'b1;
          end
        end
      end else begin
        if (tok_i.hit || (vld_r && (val_r == tok_i.data))) begin
          // close the gap: pull the right neighbor's slot in
          val_nxt     = nb_val_i;
          vld_nxt     = nb_vld_i;
          tok_nxt.hit = 1'b1;
        end
      end
    end
    if (hold) begin
      tok_nxt = tok_r;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (!rst_n) begin
      vld_r <= 1'b0;
      tok_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;
  assign val_o = val_r;
  assign vld_o = vld_r;

endmodule

FILE: src/sorted_byte_list_insert_delete_core.sv
// ----------------------------------------------------------------------------
// sorted_byte_list_insert_delete_core: bounded ascending list of bytes
// One command at a time: in_ready stays low while the command token walks
//   the row of CAPACITY cells, one cell per cycle, and returns the cycle
//   after the token retires into the result register, which raises out_valid.
//   A stalled result beat holds the token in the last cell.
// Reset (rst_n low, synchronous): list empty, no token, no result pending.
// ----------------------------------------------------------------------------
module sorted_byte_list_insert_delete_core
  import sbl_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Token chain: tok_w[0] is the launch token, tok_w[i+1] leaves cell i.
  sbl_tok_t           tok_w   [0:CAPACITY];
  // Cell contents; slot CAPACITY is a permanent empty terminator that the
  // last cell pulls in on a delete.
  logic [VALUE_W-1:0] cell_val[0:CAPACITY];
  logic               cell_vld[0:CAPACITY];
  logic [CAPACITY-1:0] tok_act_vec;

  logic               busy_r, busy_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_data_r;

  logic               in_fire;
  logic               retire;
  logic               stall;
  logic               is_full;
  sbl_tok_t           last_tok;

  // Take a new command only when no token is in the row.
  assign in_ready = !busy_r;
  assign in_fire  = in_valid && in_ready;
  assign is_full  = (count_r == CNT_W'(CAPACITY));

  // Build the launch token; a full list sends an insert token that changes nothing.
  always_comb begin
    tok_w[0].act       = in_fire;
    tok_w[0].cmd       = in_data.command;
    tok_w[0].data      = in_data.value;
    tok_w[0].carry_vld = !is_full;
    tok_w[0].hit       = 1'b0;
    tok_w[0].full      = is_full;
  end

  assign cell_val[CAPACITY] = '0;
  assign cell_vld[CAPACITY] = 1'b0;

  // Retire the token into the output register once that register is free;
  // otherwise hold it in the last cell.
  assign last_tok = tok_w[CAPACITY];
  assign retire   = last_tok.act && (!out_valid_r || out_ready);
  assign stall    = last_tok.act && !retire;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      sbl_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .hold     ((gi == CAPACITY - 1) ? stall : 1'b0),
        .tok_i    (tok_w[gi]),
        .nb_val_i (cell_val[gi+1]),
        .nb_vld_i (cell_vld[gi+1]),
        .tok_o    (tok_w[gi+1]),
        .val_o    (cell_val[gi]),
        .vld_o    (cell_vld[gi])
      );
      assign tok_act_vec[gi] = tok_w[gi+1].act;
    end
  endgenerate

  // Update the fill count when the token leaves the row.
  always_comb begin
    count_nxt = count_r;
    if (retire) begin
      if ((last_tok.cmd == CMD_INSERT) && !last_tok.full) begin
        count_nxt = count_r + CNT_W'(1);
      end else if ((last_tok.cmd == CMD_DELETE) && last_tok.hit) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (in_fire) begin
      busy_nxt = 1'b1;
    end else if (retire) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (retire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the result beat; cell 0 is settled once the token has passed.
  always_ff @(posedge clk) begin
    if (retire) begin
      if (last_tok.cmd == CMD_INSERT) begin
        out_data_r.status <= last_tok.full ? ST_FULL : ST_DONE;
      end else begin
        out_data_r.status <= last_tok.hit ? ST_DONE : ST_NOT_FOUND;
      end
      out_data_r.count    <= COUNT_W'(count_nxt);
      out_data_r.smallest <= cell_vld[0] ? cell_val[0] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_act_vec))
    else $error("more than one command token in the row");

  a_busy_token: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (|tok_act_vec))
    else $error("busy flag disagrees with token presence");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_head_cell: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (cell_vld[0] == (count_r != '0)))
    else $error("head cell valid disagrees with fill count");

  a_retire_out: assert property (@(posedge clk) disable iff (!rst_n)
    retire |=> out_valid_r)
    else $error("retired command left no result beat");
`endif

endmodule
